[design/quantized_color_mode_fill_3x3_macros.svh]
// assertion macros shared by the mode fill design
// needs clk and rst_n in the scope of each use
`ifndef QUANTIZED_COLOR_MODE_FILL_3X3_MACROS_SVH
`define QUANTIZED_COLOR_MODE_FILL_3X3_MACROS_SVH

// condition holds at every clock edge out of reset
`define QCMF_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define QCMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/qcmf_pkg.sv]
// package for the quantized color mode fill: transaction types, constants
// and color quantization helpers; no dependencies
package qcmf_pkg;

  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int LINE_W      = 2 * PIX_W;
  localparam int Q_W         = 3;
  localparam int CODE_W      = 3 * Q_W;
  localparam int NB_COUNT    = 8;
  localparam int CNT_W       = 4;
  localparam int QUANT_SHIFT = 5;

  localparam logic [CH_W-1:0]   BASE_LEVEL    = 8'd30;
  localparam logic [CODE_W-1:0] CODE_MID_MASK = 9'h038;
  localparam logic [CODE_W-1:0] CODE_LOW_MASK = 9'h007;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_REG_W   = 11;
  localparam int FH_REG_W   = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam int FRAME_MIN = 3;
  localparam int FRAME_RST = 1024;

  // output queue
  localparam int OQ_PTR_W = 3;
  localparam int OQ_DEPTH = 1 << OQ_PTR_W;
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] pixel_c0;
    logic [CH_W-1:0] pixel_c1;
    logic [CH_W-1:0] pixel_c2;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_c0;
    logic [CH_W-1:0] out_c1;
    logic [CH_W-1:0] out_c2;
    logic            filled;
    logic            any_filled;
    logic            last;
  } out_item_t;

  // control that travels with each transaction down the pipeline
  typedef struct packed {
    logic valid;
    logic pixel;
    logic emit;
    logic interior;
    logic fill;
    logic restart;
    logic upper;
    logic last;
  } item_ctl_t;

  // one column of the 3x3 window, newest row first
  typedef struct packed {
    logic [PIX_W-1:0] new_row;
    logic [PIX_W-1:0] mid_row;
    logic [PIX_W-1:0] old_row;
  } col_vec_t;

  typedef logic [NB_COUNT-1:0][CODE_W-1:0] code_vec_t;
  typedef logic [NB_COUNT-1:0][CNT_W-1:0]  cnt_vec_t;

  function automatic logic [Q_W-1:0] quant(input logic [CH_W-1:0] v);
    logic [CH_W-1:0] d;
    d = v - BASE_LEVEL;
    if (v < BASE_LEVEL) begin
      return '0;
    end
    return d[CH_W-1 -: Q_W];
  endfunction

  function automatic logic [CODE_W-1:0] code_of(input logic [PIX_W-1:0] px);
    return {quant(px[3*CH_W-1 -: CH_W]), quant(px[2*CH_W-1 -: CH_W]), quant(px[CH_W-1:0])};
  endfunction

  function automatic logic [PIX_W-1:0] dequant(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] hi;
    logic [CODE_W-1:0] mid;
    logic [CODE_W-1:0] lo;
    hi  = (code >> (2 * Q_W)) << QUANT_SHIFT;
    mid = (code & CODE_MID_MASK) << (QUANT_SHIFT - Q_W);
    lo  = (code & CODE_LOW_MASK) << QUANT_SHIFT;
    return {CH_W'(hi) + BASE_LEVEL, CH_W'(mid) + BASE_LEVEL, CH_W'(lo) + BASE_LEVEL};
  endfunction

endpackage

[design/quantized_color_mode_fill_3x3.sv]
// quantized color mode fill, 3x3: top level with position counters and stage 0
// depends on qcmf_pkg, qcmf_line_buf, qcmf_window, qcmf_vote, qcmf_out_fifo
// throughput: one transaction per clock while in_stall is low, set by the single
// read-modify-write of the line memory per pixel
// results lag the pixel stream by frame_width+1 transactions; drain flushes them
// reset (sync, rst_n low): counters and flags clear, size registers go to 1024 (or a smaller MAX_WIDTH/MAX_HEIGHT)
`include "quantized_color_mode_fill_3x3_macros.svh"
module quantized_color_mode_fill_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  qcmf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output qcmf_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qcmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qcmf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int RST_WIDTH  = (MAX_WIDTH < qcmf_pkg::FRAME_RST) ? MAX_WIDTH : qcmf_pkg::FRAME_RST;
  localparam int RST_HEIGHT = (MAX_HEIGHT < qcmf_pkg::FRAME_RST) ?
                              MAX_HEIGHT : qcmf_pkg::FRAME_RST;

  // frame geometry and positions
  logic [WID_W-1:0] width_r, width_nxt;
  logic [ROW_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [qcmf_pkg::OQ_CNT_W-1:0] credit_r, credit_nxt;
  logic [31:0] wval;
  logic [31:0] hval;

  // stage 0 decode
  logic             acc;
  logic             cfg_wr;
  logic             cfg_hit;
  logic             is_pixel;
  logic             new_frame;
  logic             pend;
  logic             emit;
  logic             col_wrap;
  logic             out_wrap;
  logic [COL_W-1:0] eff_col;
  logic [ROW_W-1:0] eff_row;
  logic [COL_W-1:0] rd_addr;
  qcmf_pkg::item_ctl_t s0_ctl;

  // stage 1
  qcmf_pkg::item_ctl_t        s1_ctl_r;
  logic [qcmf_pkg::PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0]           s1_col_r;
  logic [qcmf_pkg::LINE_W-1:0] rd_data;

  // stage 2 and 3
  qcmf_pkg::item_ctl_t           s2_ctl;
  logic [qcmf_pkg::PIX_W-1:0]    s2_pix;
  qcmf_pkg::code_vec_t           s2_codes;
  logic [qcmf_pkg::NB_COUNT-1:0] s2_nb_valid;
  logic                          push;
  qcmf_pkg::out_item_t           push_data;
  logic [qcmf_pkg::OQ_CNT_W-1:0] fifo_cnt;
  logic                          pop;

  // credit covers every result in the pipe or the queue, so the queue
  // never overflows and the pipe never stops
  assign in_stall  = credit_r >= qcmf_pkg::OQ_CNT_W'(qcmf_pkg::OQ_DEPTH);
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign pop       = out_valid && !out_stall;

  // configuration writes: clamp sizes to the legal range; a size write restarts the frame
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    cfg_hit    = 1'b0;
    wval = 32'(cfg_data[qcmf_pkg::FW_REG_W-1:0]);
    hval = 32'(cfg_data[qcmf_pkg::FH_REG_W-1:0]);
    if (cfg_wr) begin
      case (cfg_index)
        qcmf_pkg::CFG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          if (wval < 32'(qcmf_pkg::FRAME_MIN)) begin
            width_nxt = WID_W'(qcmf_pkg::FRAME_MIN);
          end else if (wval > 32'(MAX_WIDTH)) begin
            width_nxt = WID_W'(MAX_WIDTH);
          end else begin
            width_nxt = WID_W'(wval);
          end
        end
        qcmf_pkg::CFG_FRAME_HEIGHT: begin
          cfg_hit = 1'b1;
          if (hval < 32'(qcmf_pkg::FRAME_MIN)) begin
            height_nxt = ROW_W'(qcmf_pkg::FRAME_MIN);
          end else if (hval > 32'(MAX_HEIGHT)) begin
            height_nxt = ROW_W'(MAX_HEIGHT);
          end else begin
            height_nxt = ROW_W'(hval);
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // stage 0: classify the transaction and advance positions
  always_comb begin
    is_pixel  = !in_data.mode;
    // a pixel after a complete frame opens the next one
    new_frame = in_row_r == height_r;
    eff_col   = new_frame ? '0 : in_col_r;
    eff_row   = new_frame ? '0 : in_row_r;
    col_wrap  = (WID_W'(eff_col) + WID_W'(1)) == width_r;
    out_wrap  = (WID_W'(out_col_r) + WID_W'(1)) == width_r;
    // drain only after the frame is in and while results are owed
    pend      = new_frame && (out_row_r != height_r);
    if (is_pixel) begin
      // first result once the pixel right-below of the top-left one is in
      emit = (eff_row != '0) && !((eff_row == ROW_W'(1)) && (eff_col == '0));
    end else begin
      emit = pend;
    end
    rd_addr = is_pixel ? eff_col : out_col_r;

    s0_ctl.valid    = acc;
    s0_ctl.pixel    = is_pixel;
    s0_ctl.emit     = emit;
    s0_ctl.interior = is_pixel && (eff_row >= ROW_W'(2)) && (eff_col >= COL_W'(2));
    s0_ctl.fill     = 1'b0;
    s0_ctl.restart  = is_pixel && new_frame;
    s0_ctl.upper    = out_row_r == (height_r - ROW_W'(1));
    s0_ctl.last     = (out_row_r == (height_r - ROW_W'(1))) &&
                      (WID_W'(out_col_r) == (width_r - WID_W'(1)));

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (acc) begin
      if (is_pixel) begin
        if (col_wrap) begin
          in_col_nxt = '0;
          in_row_nxt = eff_row + ROW_W'(1);
        end else begin
          in_col_nxt = eff_col + COL_W'(1);
          in_row_nxt = eff_row;
        end
        if (new_frame) begin
          // results of the old frame still owed are dropped
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
      if (emit) begin
        if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end

    credit_nxt = credit_r;
    if ((acc && emit) && !pop) begin
      credit_nxt = credit_r + qcmf_pkg::OQ_CNT_W'(1);
    end else if (pop && !(acc && emit)) begin
      credit_nxt = credit_r - qcmf_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WID_W'(RST_WIDTH);
      height_r  <= ROW_W'(RST_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      credit_r  <= '0;
      s1_ctl_r  <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      credit_r  <= credit_nxt;
      s1_ctl_r  <= s0_ctl;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r <= {in_data.pixel_c0, in_data.pixel_c1, in_data.pixel_c2};
    s1_col_r <= rd_addr;
  end

  // line memory: read at accept, write back in stage 1
  qcmf_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .wr_en   (s1_ctl_r.valid && s1_ctl_r.pixel),
    .wr_addr (s1_col_r),
    .wr_pix  (s1_pix_r),
    .rd_data (rd_data)
  );

  qcmf_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_ctl      (s1_ctl_r),
    .s1_pix      (s1_pix_r),
    .rd_data     (rd_data),
    .s2_ctl      (s2_ctl),
    .s2_pix      (s2_pix),
    .s2_codes    (s2_codes),
    .s2_nb_valid (s2_nb_valid)
  );

  qcmf_vote u_vote (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_hit),
    .s2_ctl      (s2_ctl),
    .s2_pix      (s2_pix),
    .s2_codes    (s2_codes),
    .s2_nb_valid (s2_nb_valid),
    .push        (push),
    .push_data   (push_data)
  );

  qcmf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cnt       (fifo_cnt)
  );

  // queued results never outnumber the credits taken for them
  `QCMF_ASSERT_HOLDS(a_credit_covers_queue, credit_r >= fifo_cnt, "queue holds uncredited results")
  // output position never passes the input position or the frame end
  `QCMF_ASSERT_HOLDS(a_out_behind_in, (in_row_r <= height_r) && (out_row_r <= in_row_r), "position order broken")
  // a size write restarts every position counter
  `QCMF_ASSERT_NEXT(a_cfg_restart, cfg_valid && cfg_ready && (cfg_index == qcmf_pkg::CFG_FRAME_WIDTH || cfg_index == qcmf_pkg::CFG_FRAME_HEIGHT), (in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0), "frame not restarted")

endmodule

[design/qcmf_line_buf.sv]
// two-row line memory, one entry per column, read-modify-write each pixel
// depends on qcmf_pkg
module qcmf_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [qcmf_pkg::PIX_W-1:0]  wr_pix,
  output logic [qcmf_pkg::LINE_W-1:0] rd_data
);

  logic [qcmf_pkg::LINE_W-1:0] line_mem [DEPTH];
  logic [qcmf_pkg::LINE_W-1:0] rd_q_r;
  logic [qcmf_pkg::LINE_W-1:0] fwd_data_r;
  logic [qcmf_pkg::LINE_W-1:0] wr_data;
  logic                        fwd_r;

  // entry holds {row above, two rows above}; new pixel shifts in on top
  assign wr_data = {wr_pix, rd_data[qcmf_pkg::LINE_W-1 -: qcmf_pkg::PIX_W]};
  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= line_mem[rd_addr];
    end
    fwd_data_r <= wr_data;
  end

  // read of the entry being written in the same cycle takes the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

endmodule

[design/qcmf_window.sv]
// 3x3 window columns, neighbor quantization and center selection
// depends on qcmf_pkg
module qcmf_window (
  input  logic                        clk,
  input  logic                        rst_n,
  input  qcmf_pkg::item_ctl_t         s1_ctl,
  input  logic [qcmf_pkg::PIX_W-1:0]  s1_pix,
  input  logic [qcmf_pkg::LINE_W-1:0] rd_data,
  output qcmf_pkg::item_ctl_t         s2_ctl,
  output logic [qcmf_pkg::PIX_W-1:0]  s2_pix,
  output qcmf_pkg::code_vec_t         s2_codes,
  output logic [qcmf_pkg::NB_COUNT-1:0] s2_nb_valid
);

  qcmf_pkg::col_vec_t w1_r;
  qcmf_pkg::col_vec_t w2_r;
  qcmf_pkg::col_vec_t cur_col;
  qcmf_pkg::item_ctl_t s2_ctl_r;
  qcmf_pkg::item_ctl_t ctl_nxt;
  qcmf_pkg::code_vec_t codes_r;
  qcmf_pkg::code_vec_t codes_nxt;
  logic [qcmf_pkg::NB_COUNT-1:0] nb_valid_r;
  logic [qcmf_pkg::NB_COUNT-1:0] nb_valid_nxt;
  logic [qcmf_pkg::NB_COUNT-1:0][qcmf_pkg::PIX_W-1:0] nb_pix;
  logic [qcmf_pkg::PIX_W-1:0] center;
  logic [qcmf_pkg::PIX_W-1:0] pix_r;
  logic [qcmf_pkg::PIX_W-1:0] pix_nxt;

  always_comb begin
    cur_col.new_row = s1_pix;
    cur_col.mid_row = rd_data[qcmf_pkg::LINE_W-1 -: qcmf_pkg::PIX_W];
    cur_col.old_row = rd_data[qcmf_pkg::PIX_W-1:0];
    center = w1_r.mid_row;
    nb_pix[0] = w2_r.new_row;
    nb_pix[1] = w2_r.mid_row;
    nb_pix[2] = w2_r.old_row;
    nb_pix[3] = w1_r.new_row;
    nb_pix[4] = w1_r.old_row;
    nb_pix[5] = cur_col.new_row;
    nb_pix[6] = cur_col.mid_row;
    nb_pix[7] = cur_col.old_row;
    for (int i = 0; i < qcmf_pkg::NB_COUNT; i++) begin
      codes_nxt[i]    = qcmf_pkg::code_of(nb_pix[i]);
      nb_valid_nxt[i] = nb_pix[i][qcmf_pkg::PIX_W-1 -: qcmf_pkg::CH_W] != '0;
    end
    // drain reads its pixel straight from the line memory
    if (s1_ctl.pixel) begin
      pix_nxt = center;
    end else if (s1_ctl.upper) begin
      pix_nxt = cur_col.mid_row;
    end else begin
      pix_nxt = cur_col.old_row;
    end
    ctl_nxt      = s1_ctl;
    ctl_nxt.fill = s1_ctl.valid && s1_ctl.interior &&
                   (center[qcmf_pkg::PIX_W-1 -: qcmf_pkg::CH_W] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl.valid && s1_ctl.pixel) begin
      w1_r <= cur_col;
      w2_r <= w1_r;
    end
    pix_r      <= pix_nxt;
    codes_r    <= codes_nxt;
    nb_valid_r <= nb_valid_nxt;
  end

  assign s2_ctl      = s2_ctl_r;
  assign s2_pix      = pix_r;
  assign s2_codes    = codes_r;
  assign s2_nb_valid = nb_valid_r;

endmodule

[design/qcmf_vote.sv]
// neighbor histogram, mode selection and output formatting
// depends on qcmf_pkg
module qcmf_vote (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  qcmf_pkg::item_ctl_t           s2_ctl,
  input  logic [qcmf_pkg::PIX_W-1:0]    s2_pix,
  input  qcmf_pkg::code_vec_t           s2_codes,
  input  logic [qcmf_pkg::NB_COUNT-1:0] s2_nb_valid,
  output logic                          push,
  output qcmf_pkg::out_item_t           push_data
);

  qcmf_pkg::cnt_vec_t  cnt_nxt;
  qcmf_pkg::cnt_vec_t  cnt_r;
  qcmf_pkg::code_vec_t codes_r;
  qcmf_pkg::item_ctl_t s3_ctl_r;
  logic [qcmf_pkg::NB_COUNT-1:0] nb_valid_r;
  logic [qcmf_pkg::PIX_W-1:0]    pix_r;
  logic [qcmf_pkg::PIX_W-1:0]    res_pix;
  logic [qcmf_pkg::CODE_W-1:0]   best;
  logic [qcmf_pkg::CNT_W-1:0]    best_cnt;
  logic                          seen_r;
  logic                          seen_nxt;

  // occurrences of each neighbor's code among the colored neighbors
  always_comb begin
    for (int i = 0; i < qcmf_pkg::NB_COUNT; i++) begin
      cnt_nxt[i] = '0;
      for (int j = 0; j < qcmf_pkg::NB_COUNT; j++) begin
        if (s2_nb_valid[j] && (s2_codes[j] == s2_codes[i])) begin
          cnt_nxt[i] = cnt_nxt[i] + qcmf_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
      seen_r   <= 1'b0;
    end else begin
      s3_ctl_r <= s2_ctl;
      seen_r   <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    codes_r    <= s2_codes;
    nb_valid_r <= s2_nb_valid;
    pix_r      <= s2_pix;
  end

  // highest count wins, lower code on a tie
  always_comb begin
    best     = '0;
    best_cnt = '0;
    for (int i = 0; i < qcmf_pkg::NB_COUNT; i++) begin
      if (nb_valid_r[i] && ((cnt_r[i] > best_cnt) ||
          ((cnt_r[i] == best_cnt) && (codes_r[i] < best)))) begin
        best     = codes_r[i];
        best_cnt = cnt_r[i];
      end
    end
  end

  always_comb begin
    push    = s3_ctl_r.valid && s3_ctl_r.emit;
    res_pix = s3_ctl_r.fill ? qcmf_pkg::dequant(best) : pix_r;
    push_data.out_c0     = res_pix[qcmf_pkg::PIX_W-1 -: qcmf_pkg::CH_W];
    push_data.out_c1     = res_pix[2*qcmf_pkg::CH_W-1 -: qcmf_pkg::CH_W];
    push_data.out_c2     = res_pix[qcmf_pkg::CH_W-1:0];
    push_data.filled     = s3_ctl_r.fill;
    push_data.any_filled = seen_r || s3_ctl_r.fill;
    push_data.last       = s3_ctl_r.last;
    seen_nxt = seen_r;
    if (clear) begin
      seen_nxt = 1'b0;
    end else if (s3_ctl_r.valid && s3_ctl_r.restart) begin
      seen_nxt = 1'b0;
    end else if (push && s3_ctl_r.fill) begin
      seen_nxt = 1'b1;
    end
  end

endmodule

[design/qcmf_out_fifo.sv]
// result queue between the pipeline and the output channel
// depends on qcmf_pkg
module qcmf_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  qcmf_pkg::out_item_t            push_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output qcmf_pkg::out_item_t            out_data,
  output logic [qcmf_pkg::OQ_CNT_W-1:0]  cnt
);

  qcmf_pkg::out_item_t oq_mem [qcmf_pkg::OQ_DEPTH];
  logic [qcmf_pkg::OQ_PTR_W-1:0] wr_ptr_r;
  logic [qcmf_pkg::OQ_PTR_W-1:0] rd_ptr_r;
  logic [qcmf_pkg::OQ_CNT_W-1:0] cnt_r;
  logic [qcmf_pkg::OQ_CNT_W-1:0] cnt_nxt;
  logic                          pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = oq_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign cnt       = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + qcmf_pkg::OQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - qcmf_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + qcmf_pkg::OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + qcmf_pkg::OQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for quantized_color_mode_fill_3x3: pixel and drain transactions
// are checked field by field against an in-bench model of the 3x3 mode fill
// depends on qcmf_pkg and the quantized_color_mode_fill_3x3 design sources
module tb_top;
  import qcmf_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  // history window: two full rows plus the 3x3 overhang
  localparam int HIST_DEPTH    = 2 * MAX_W + 4;
  localparam int RAND_ITEMS    = 1050;
  // cycles to let the pipeline go quiet before a register write
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int MAX_PRINTS    = 30;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [CH_W-1:0] BG_C0 = 8'd0;

  // expected output pixels of the mode fill, plus the frame state that produces them
  class fill_scoreboard;
    int frame_w;
    int frame_h;
    int in_col;
    int in_row;
    int out_pos;
    int out_col;
    int out_row;
    bit seen_fill;
    logic [PIX_W-1:0] hist [HIST_DEPTH];
    out_item_t expected_q[$];
    int useful_items;
    int errors;
    int checked;

    function new();
      foreach (hist[i]) hist[i] = '0;
      frame_w = FRAME_RST;
      frame_h = FRAME_RST;
      useful_items = 0;
      errors = 0;
      checked = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      in_col = 0;
      in_row = 0;
      out_pos = 0;
      out_col = 0;
      out_row = 0;
      seen_fill = 1'b0;
    endfunction

    function int clamp_size(int v, int hi);
      if (v < FRAME_MIN) return FRAME_MIN;
      return (v > hi) ? hi : v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_FRAME_WIDTH) begin
        frame_w = clamp_size(int'(value[FW_REG_W-1:0]), MAX_W);
      end else if (idx == CFG_FRAME_HEIGHT) begin
        frame_h = clamp_size(int'(value[FH_REG_W-1:0]), MAX_H);
      end else begin
        return;
      end
      restart_frame();
    endfunction

    function logic [Q_W-1:0] quantize(logic [CH_W-1:0] v);
      int q;
      if (v < BASE_LEVEL) return '0;
      q = (int'(v) - int'(BASE_LEVEL)) / 32;
      return (q > 7) ? Q_W'(7) : Q_W'(q);
    endfunction

    function logic [CODE_W-1:0] color_code(logic [PIX_W-1:0] px);
      return {quantize(px[23:16]), quantize(px[15:8]), quantize(px[7:0])};
    endfunction

    function logic [CH_W-1:0] level(logic [Q_W-1:0] q);
      return CH_W'(int'(q) * 32 + int'(BASE_LEVEL));
    endfunction

    // output pixel at out_pos: pass-through, or neighbor mode for interior background
    function out_item_t next_result();
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] nb;
      logic [CODE_W-1:0] codes [8];
      logic [CODE_W-1:0] best;
      bit colored [8];
      int n;
      int cnt;
      int best_cnt;
      bit fill;
      out_item_t r;
      px = hist[out_pos % HIST_DEPTH];
      fill = out_row >= 1 && out_row + 1 < frame_h && out_col >= 1 && out_col + 1 < frame_w
             && px[PIX_W-1 -: CH_W] == BG_C0;
      if (fill) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              nb = hist[(out_pos + dr * frame_w + dc) % HIST_DEPTH];
              colored[n] = nb[PIX_W-1 -: CH_W] != BG_C0;
              codes[n] = color_code(nb);
              n++;
            end
          end
        end
        // most frequent code among colored neighbors, ties to the lower code
        best = '0;
        best_cnt = 0;
        for (int i = 0; i < 8; i++) begin
          if (!colored[i]) continue;
          cnt = 0;
          for (int j = 0; j < 8; j++) begin
            if (colored[j] && codes[j] == codes[i]) cnt++;
          end
          if (cnt > best_cnt || (cnt == best_cnt && codes[i] < best)) begin
            best_cnt = cnt;
            best = codes[i];
          end
        end
        px = {level(best[8:6]), level(best[5:3]), level(best[2:0])};
        seen_fill = 1'b1;
      end
      r.out_c0 = px[23:16];
      r.out_c1 = px[15:8];
      r.out_c2 = px[7:0];
      r.filled = fill;
      r.any_filled = seen_fill;
      r.last = (out_pos + 1 == frame_w * frame_h);
      out_pos++;
      out_col++;
      if (out_col >= frame_w) begin
        out_col = 0;
        out_row++;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      int count;
      if (it.mode == MODE_DRAIN) begin
        // drains only act once the frame is in and pixels are still pending
        if (in_row >= frame_h && out_pos < frame_w * frame_h) begin
          expected_q.push_back(next_result());
          useful_items++;
        end
        return;
      end
      if (in_row >= frame_h) restart_frame();
      hist[(in_row * frame_w + in_col) % HIST_DEPTH] = {it.pixel_c0, it.pixel_c1, it.pixel_c2};
      useful_items++;
      in_col++;
      if (in_col >= frame_w) begin
        in_col = 0;
        in_row++;
      end
      count = in_row * frame_w + in_col;
      if (count - out_pos >= frame_w + 2) expected_q.push_back(next_result());
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at output %0d: %s", checked, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected output %h", got));
        checked++;
        return;
      end
      want = expected_q.pop_front();
      if (got.out_c0 !== want.out_c0)
        report_mismatch($sformatf("out_c0 %0d, want %0d", got.out_c0, want.out_c0));
      if (got.out_c1 !== want.out_c1)
        report_mismatch($sformatf("out_c1 %0d, want %0d", got.out_c1, want.out_c1));
      if (got.out_c2 !== want.out_c2)
        report_mismatch($sformatf("out_c2 %0d, want %0d", got.out_c2, want.out_c2));
      if (got.filled !== want.filled)
        report_mismatch($sformatf("filled %b, want %b", got.filled, want.filled));
      if (got.any_filled !== want.any_filled)
        report_mismatch($sformatf("any_filled %b, want %b", got.any_filled, want.any_filled));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  fill_scoreboard sb;
  // idle odds per cycle, in percent, for the sender and the receiver
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  // one-shot request for a long receiver hold-off
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  // a few colors shared by one frame so that neighbor votes collide
  logic [PIX_W-1:0] palette [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quantized_color_mode_fill_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // receiver: random stall, or a long hold-off counted here when asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // every accepted transaction on the three channels goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("quantized_color_mode_fill_3x3 regression: fail");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic in_item_t pix(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
                                   logic [CH_W-1:0] c2);
    return {MODE_PIXEL, c0, c1, c2};
  endfunction

  // drain transaction, channels are don't-care so they get random bits
  function automatic in_item_t drain_item();
    in_item_t it;
    it.mode = MODE_DRAIN;
    {it.pixel_c0, it.pixel_c1, it.pixel_c2} = PIX_W'($urandom);
    return it;
  endfunction

  // background, a palette color, or anything at all
  function automatic in_item_t pick_pixel();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.mode = MODE_PIXEL;
    if (r < 35) begin
      {it.pixel_c0, it.pixel_c1, it.pixel_c2} = {BG_C0, 16'($urandom)};
    end else if (r < 85) begin
      {it.pixel_c0, it.pixel_c1, it.pixel_c2} = palette[$urandom_range(0, 2)];
    end else begin
      {it.pixel_c0, it.pixel_c1, it.pixel_c2} = PIX_W'($urandom);
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop sending until every expected pixel is out and the pipeline is quiet
  task automatic pause_sender();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    pause_sender();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // small sizes; width data carries junk above the 11 register bits
  task automatic random_config();
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;
    wd = CFG_DATA_W'(($urandom_range(0, 3) << FW_REG_W) | $urandom_range(0, 10));
    hd = CFG_DATA_W'($urandom_range(0, 7));
    case ($urandom_range(0, 2))
      0: write_cfg(CFG_FRAME_WIDTH, wd);
      1: write_cfg(CFG_FRAME_HEIGHT, hd);
      default: begin
        write_cfg(CFG_FRAME_HEIGHT, hd);
        write_cfg(CFG_FRAME_WIDTH, wd);
      end
    endcase
  endtask

  // one frame at the current size; pix_cap > 0 cuts it short with no drain
  task automatic run_frame(int pix_cap);
    int npix;
    int cut;
    int drains;
    npix = sb.frame_w * sb.frame_h;
    cut = (pix_cap > 0 && pix_cap < npix) ? pix_cap : npix;
    foreach (palette[k]) palette[k] = {8'($urandom_range(1, 255)), 16'($urandom)};
    for (int p = 0; p < cut; p++) begin
      // stray drain inside the frame
      if ($urandom_range(0, 29) == 0) send_item(drain_item());
      send_item(pick_pixel());
    end
    if (cut < npix) return;
    drains = sb.frame_w + 1;
    case ($urandom_range(0, 9))
      0: drains = $urandom_range(0, sb.frame_w);   // next frame drops the rest
      1, 2: drains += $urandom_range(1, 3);        // drains with nothing pending
      default: ;
    endcase
    repeat (drains) send_item(drain_item());
  endtask

  task automatic random_frames(int quota);
    int stop_at;
    int npix;
    stop_at = sb.useful_items + quota;
    while (sb.useful_items < stop_at) begin
      if ($urandom_range(0, 3) == 0) random_config();
      npix = sb.frame_w * sb.frame_h;
      if ($urandom_range(0, 19) == 0) begin
        run_frame($urandom_range(1, npix - 1));
      end else begin
        run_frame(0);
      end
      if ($urandom_range(0, 7) == 0) pause_sender();
    end
  endtask

  initial begin
    in_item_t hue_hi;
    in_item_t hue_lo;
    sb = new();
    // code 448 and code 1 neighbors, four of each around the center
    hue_hi = pix(8'd255, 8'd0, 8'd29);
    hue_lo = pix(8'd30, 8'd61, 8'd62);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // smallest frame, both sizes below range so both clamp up to 3
    write_cfg(CFG_FRAME_WIDTH, 13'd0);
    write_cfg(CFG_FRAME_HEIGHT, 13'd2);
    send_item(drain_item());                  // drain before any pixel
    send_item(hue_hi);
    send_item(hue_lo);
    send_item(hue_hi);
    send_item(hue_lo);
    send_item(pix(BG_C0, 8'd77, 8'd88));      // center, 4-4 tie goes to the lower code
    write_cfg(CFG_SPARE_IDX, 13'h1fff);       // unused index must not restart the frame
    send_item(hue_hi);
    send_item(hue_lo);
    send_item(hue_lo);
    send_item(hue_hi);
    repeat (4) send_item(drain_item());
    send_item(drain_item());                  // nothing left to drain
    // all background: center takes code 0, border pixels pass through
    for (int k = 0; k < 9; k++) begin
      if (k == 4) begin
        send_item(pix(BG_C0, 8'h80, 8'h01));
      end else begin
        send_item(pix(BG_C0, (k % 2) ? 8'h00 : 8'hff, (k % 2) ? 8'h00 : 8'hff));
      end
    end
    send_item(pix(8'd1, 8'h55, 8'haa));       // new frame drops the undrained pixels

    // phase one: receiver mostly stalled, with one long hold-off that backs up the input
    snd_idle_pct = 36;
    rcv_idle_pct = 85;
    write_cfg(CFG_FRAME_WIDTH, 13'd10);
    write_cfg(CFG_FRAME_HEIGHT, 13'd6);
    hold_req = 1'b1;
    run_frame(0);
    pause_sender();
    random_frames(RAND_ITEMS / 3);

    // phase two: sender mostly idle
    snd_idle_pct = 85;
    rcv_idle_pct = 36;
    random_frames(RAND_ITEMS / 3);

    // phase three: full rate both ways
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_frames(RAND_ITEMS - 2 * (RAND_ITEMS / 3));

    // widest row: 2047 clamps down to 1024
    write_cfg(CFG_FRAME_WIDTH, 13'h07ff);
    write_cfg(CFG_FRAME_HEIGHT, 13'd3);
    run_frame(0);
    // tallest frame, only its first rows; height 8191 clamps down to 4096
    write_cfg(CFG_FRAME_WIDTH, 13'h1803);
    write_cfg(CFG_FRAME_HEIGHT, 13'h1fff);
    run_frame(60);

    pause_sender();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("quantized_color_mode_fill_3x3 regression: pass");
    end else begin
      $display("quantized_color_mode_fill_3x3 regression: fail");
    end
    $finish;
  end

endmodule
